@@ src/mlbs_pkg.sv @@
// Shared types and constants for the multichannel LED blink sequencer.
`timescale 1ns / 1ps

package mlbs_pkg;

    localparam int DEF_CHANNELS      = 96;
    localparam int DEF_PROGRAM_DEPTH = 64;

    localparam int FRAME_BYTES = 12;
    localparam int LEDS        = 96;

    localparam int STATUS_W  = 8;
    localparam int ON_BIT    = 7;
    localparam logic [STATUS_W-1:0] COUNT_MASK = 8'h7F;

    localparam int MODE_W    = 2;
    localparam int CH_IN_W   = 7;
    localparam int ADDR_IN_W = 6;
    localparam int WORD_W    = 8;
    localparam int S_DATA_W  = 24;

    localparam int BYTE_IDX_W = 4;
    localparam int M_DATA_W   = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_CODE = 1'b0,
        CFG_HALT_CODE = 1'b1
    } cfg_idx_t;

    typedef logic [FRAME_BYTES-1:0][7:0] led_frame_t;

endpackage

@@ src/mlbs_frame_tx.sv @@
// Frame serializer: sends the twelve LED bytes of a frame through an output register.
`timescale 1ns / 1ps

module mlbs_frame_tx
    import mlbs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                frame_start,
    input  led_frame_t          led_frame,
    output logic                frame_done,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // led_byte[7:0], byte_index[11:8], zero pad
    output logic                m_tlast   // last_byte
);

    localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(FRAME_BYTES - 1);

    logic                  busy_reg;
    logic [BYTE_IDX_W-1:0] idx_reg;
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  load;

    assign load       = busy_reg && (!m_tvalid_reg || m_tready);
    assign frame_done = load && (idx_reg == LAST_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (frame_start) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (load) begin
                if (idx_reg == LAST_IDX) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {{(M_DATA_W - BYTE_IDX_W - 8){1'b0}}, idx_reg, led_frame[idx_reg]};
            m_tlast_reg <= (idx_reg == LAST_IDX);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ src/multichannel_led_blink_sequencer_core.sv @@
// Top level: program store, per-channel blink state and the channel sequencer.
// Load: accepted while idle, no result.
// Tick: each channel passes S_SREAD and S_SEVAL when counting, adds S_PEVAL on a fetch
//   and a second S_PEVAL when a loop word restarts it; one shared state memory port and
//   one program memory port set this. Then 12 bytes leave at one per cycle while m_tready is high.
// Restart: clears the channels and sends a zero frame. Reset clears position and status through
//   per-channel valid flags at once; the program store holds garbage until loaded.
`timescale 1ns / 1ps

module multichannel_led_blink_sequencer_core
    import mlbs_pkg::*;
#(
    parameter int CHANNELS      = DEF_CHANNELS,
    parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // channel[6:0], word_address[12:7], word_value[20:13], zero pad
    input  logic [MODE_W-1:0]     s_tuser,   // mode[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // led_byte[7:0], byte_index[11:8], zero pad
    output logic                  m_tlast,   // last_byte
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CH_W    = $clog2(CHANNELS);
    localparam int POS_W   = $clog2(PROGRAM_DEPTH);
    localparam int ST_W    = POS_W + STATUS_W;
    localparam int PG_A_W  = CH_W + POS_W;
    localparam int PG_SIZE = CHANNELS * (2 ** POS_W);
    localparam int ADDR_IN_N = 2 ** ADDR_IN_W;

    localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(CHANNELS - 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PROGRAM_DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SREAD = 5'b00010,
        S_SEVAL = 5'b00100,
        S_PEVAL = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [CH_W-1:0]       ch_reg, ch_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  looped_reg, looped_next;
    logic [CHANNELS-1:0]   valid_reg, valid_next;
    logic [CHANNELS-1:0]   led_reg, led_next;
    logic                  tx_start_reg, tx_start_next;
    logic [WORD_W-1:0]     loop_code_reg;
    logic [WORD_W-1:0]     halt_code_reg;

    logic [ST_W-1:0]       st_mem [CHANNELS];
    logic [ST_W-1:0]       st_q;
    logic                  st_valid_q;
    logic                  st_rd_en;
    logic                  st_wr_en;
    logic [ST_W-1:0]       st_wdata;

    logic [WORD_W-1:0]     pg_mem [PG_SIZE];
    logic [WORD_W-1:0]     pg_q;
    logic                  pg_rd_en;
    logic [PG_A_W-1:0]     pg_raddr;
    logic                  pg_wr_en;
    logic [PG_A_W-1:0]     pg_waddr;

    logic [POS_W-1:0]      wrap_lut [ADDR_IN_N];

    logic                  s_fire;
    mode_t                 s_mode;
    logic [CH_IN_W-1:0]    s_channel;
    logic [ADDR_IN_W-1:0]  s_word_address;
    logic [WORD_W-1:0]     s_word_value;

    logic [STATUS_W-1:0]   cur_status;
    logic [POS_W-1:0]      cur_pos;
    logic [STATUS_W-1:0]   new_status;
    logic [POS_W-1:0]      new_pos;
    logic [POS_W-1:0]      adv_pos;

    logic                  tx_done;
    led_frame_t            led_frame;

    for (genvar i = 0; i < ADDR_IN_N; i++) begin : g_wrap
        assign wrap_lut[i] = POS_W'(i % PROGRAM_DEPTH);
    end

    assign s_tready       = (state_reg == S_IDLE);
    assign s_fire         = s_tvalid && s_tready;
    assign s_mode         = mode_t'(s_tuser);
    assign s_channel      = s_tdata[CH_IN_W-1:0];
    assign s_word_address = s_tdata[CH_IN_W +: ADDR_IN_W];
    assign s_word_value   = s_tdata[CH_IN_W + ADDR_IN_W +: WORD_W];

    assign pg_wr_en = s_fire && (s_mode == MODE_LOAD)
                      && ({1'b0, s_channel} < (CH_IN_W + 1)'(CHANNELS));
    assign pg_waddr = {CH_W'(s_channel), wrap_lut[s_word_address]};

    assign cur_status = st_valid_q ? st_q[STATUS_W-1:0] : '0;
    assign cur_pos    = st_valid_q ? st_q[ST_W-1:STATUS_W] : '0;
    assign adv_pos    = (pos_reg == LAST_POS) ? '0 : POS_W'(pos_reg + 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_code_reg <= 8'd128;
            halt_code_reg <= 8'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOOP_CODE: loop_code_reg <= cfg_wdata;
                CFG_HALT_CODE: halt_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pg_wr_en) begin
            pg_mem[pg_waddr] <= s_word_value;
        end
        if (pg_rd_en) begin
            pg_q <= pg_mem[pg_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_wr_en) begin
            st_mem[ch_reg] <= st_wdata;
        end
        if (st_rd_en) begin
            st_q       <= st_mem[ch_reg];
            st_valid_q <= valid_reg[ch_reg];
        end
    end

    always_comb begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        pos_next      = pos_reg;
        status_next   = status_reg;
        looped_next   = looped_reg;
        valid_next    = valid_reg;
        led_next      = led_reg;
        tx_start_next = 1'b0;
        st_rd_en      = 1'b0;
        st_wr_en      = 1'b0;
        st_wdata      = {pos_reg, status_reg};
        pg_rd_en      = 1'b0;
        pg_raddr      = {ch_reg, pos_reg};
        new_status    = status_reg;
        new_pos       = pos_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    unique case (s_mode)
                        MODE_TICK: begin
                            ch_next    = '0;
                            state_next = S_SREAD;
                        end
                        MODE_RESTART: begin
                            valid_next    = '0;
                            led_next      = '0;
                            tx_start_next = 1'b1;
                            state_next    = S_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_SREAD: begin
                st_rd_en   = 1'b1;
                state_next = S_SEVAL;
            end
            S_SEVAL: begin
                if ((cur_status & COUNT_MASK) != '0) begin
                    st_wr_en           = 1'b1;
                    st_wdata           = {cur_pos, STATUS_W'(cur_status - 1'b1)};
                    valid_next[ch_reg] = 1'b1;
                    led_next[ch_reg]   = cur_status[ON_BIT];
                    if (ch_reg == LAST_CH) begin
                        tx_start_next = 1'b1;
                        state_next    = S_EMIT;
                    end else begin
                        ch_next    = CH_W'(ch_reg + 1'b1);
                        state_next = S_SREAD;
                    end
                end else begin
                    pos_next    = cur_pos;
                    status_next = cur_status;
                    looped_next = 1'b0;
                    pg_rd_en    = 1'b1;
                    pg_raddr    = {ch_reg, cur_pos};
                    state_next  = S_PEVAL;
                end
            end
            S_PEVAL: begin
                if ((pg_q == loop_code_reg) && !looped_reg) begin
                    pg_rd_en    = 1'b1;
                    pg_raddr    = {ch_reg, {POS_W{1'b0}}};
                    pos_next    = '0;
                    looped_next = 1'b1;
                end else begin
                    if (pg_q != halt_code_reg) begin
                        new_status = pg_q;
                        new_pos    = adv_pos;
                    end
                    st_wr_en           = 1'b1;
                    st_wdata           = {new_pos, new_status};
                    valid_next[ch_reg] = 1'b1;
                    led_next[ch_reg]   = new_status[ON_BIT];
                    if (ch_reg == LAST_CH) begin
                        tx_start_next = 1'b1;
                        state_next    = S_EMIT;
                    end else begin
                        ch_next    = CH_W'(ch_reg + 1'b1);
                        state_next = S_SREAD;
                    end
                end
            end
            S_EMIT: begin
                if (tx_done) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ch_reg       <= '0;
            looped_reg   <= 1'b0;
            valid_reg    <= '0;
            led_reg      <= '0;
            tx_start_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            looped_reg   <= looped_next;
            valid_reg    <= valid_next;
            led_reg      <= led_next;
            tx_start_reg <= tx_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        status_reg <= status_next;
    end

    assign led_frame = led_frame_t'(LEDS'(led_reg));

    mlbs_frame_tx u_frame_tx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_start (tx_start_reg),
        .led_frame   (led_frame),
        .frame_done  (tx_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the LED blink sequencer: load/tick/restart streams, local model.
`timescale 1ns / 1ps

module tb_top;
    import mlbs_pkg::*;

    localparam int CHANNELS      = DEF_CHANNELS;
    localparam int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH;
    localparam int LIMIT_CYCLES  = 400_000;
    localparam int PHASE_ITEMS   = 40;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [CH_IN_W-1:0]   channel;
        logic [ADDR_IN_W-1:0] addr;
        logic [WORD_W-1:0]    value;
    } stim_word_t;

    typedef struct packed {
        logic [7:0]            led;
        logic [BYTE_IDX_W-1:0] index;
        logic                  last;
    } led_byte_t;

    typedef struct packed {
        logic [CHANNELS-1:0][ADDR_IN_W-1:0] pos;
        logic [CHANNELS-1:0][STATUS_W-1:0]  status;
    } chan_state_t;

    typedef logic [CHANNELS-1:0][PROGRAM_DEPTH-1:0][WORD_W-1:0] prog_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    multichannel_led_blink_sequencer_core #(
        .CHANNELS      (CHANNELS),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    stim_word_t pending_words[$];
    led_byte_t  exp_byte_q[$];

    logic [WORD_W-1:0] loop_code_r = 8'd128;
    logic [WORD_W-1:0] halt_code_r = 8'd0;

    chan_state_t live_st   = '0;
    prog_t       live_prog = '0;
    chan_state_t plan_st   = '0;
    prog_t       plan_prog = '0;
    logic [CHANNELS-1:0][PROGRAM_DEPTH-1:0] plan_written = '0;

    int unsigned queued_total   = 0;
    int unsigned accepted_total = 0;
    int unsigned planned_items  = 0;
    int unsigned bytes_checked  = 0;
    int unsigned err_count      = 0;
    int unsigned cycle_count    = 0;
    int unsigned n_ticks        = 0;
    int unsigned n_restarts     = 0;
    int unsigned n_loads        = 0;
    int unsigned n_noise        = 0;

    stim_word_t drv_word;
    led_byte_t  want;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic chan_state_t blink_step(chan_state_t st, prog_t prog);
        chan_state_t       nxt;
        logic [ADDR_IN_W-1:0] p;
        logic [WORD_W-1:0]    w;
        nxt = st;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if ((st.status[ch] & COUNT_MASK) != '0) begin
                nxt.status[ch] = st.status[ch] - 8'd1;
            end else begin
                p = st.pos[ch];
                w = prog[ch][p];
                if (w == loop_code_r) begin
                    p = '0;
                    w = prog[ch][0];
                end
                if (w != halt_code_r) begin
                    nxt.status[ch] = w;
                    p = p + 1'b1;
                end
                nxt.pos[ch] = p;
            end
        end
        return nxt;
    endfunction

    function automatic led_frame_t led_frame_of(chan_state_t st);
        led_frame_t f;
        f = '0;
        for (int ch = 0; ch < CHANNELS; ch++)
            f[ch / 8][ch % 8] = st.status[ch][ON_BIT];
        return f;
    endfunction

    function automatic bit take_break();
        bit calm;
        calm = (accepted_total >= 120 && accepted_total < 220);
        return !calm && ($urandom_range(0, 99) < 21);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word(int addr);
        int unsigned r;
        int unsigned c;
        r = $urandom_range(0, 99);
        c = $urandom_range(0, 99);
        if (addr != 0 && r < 40)
            return loop_code_r;
        if (r < 48)
            return halt_code_r;
        if (c < 70)
            return {1'($urandom), 7'($urandom_range(0, 3))};
        if (c < 80)
            return {1'($urandom), 7'h7F};
        return 8'($urandom);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    task automatic queue_led_frame(input led_frame_t f);
        led_byte_t b;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            b.led   = f[k];
            b.index = k[BYTE_IDX_W-1:0];
            b.last  = (k == FRAME_BYTES - 1);
            exp_byte_q.push_back(b);
        end
    endtask

    task automatic push_word(input stim_word_t w);
        pending_words.push_back(w);
        queued_total++;
    endtask

    task automatic queue_load(input int ch, input int addr, input logic [WORD_W-1:0] v);
        stim_word_t w;
        w.mode    = MODE_LOAD;
        w.channel = ch[CH_IN_W-1:0];
        w.addr    = addr[ADDR_IN_W-1:0];
        w.value   = v;
        push_word(w);
        if (ch < CHANNELS) begin
            plan_prog[ch][addr]    = v;
            plan_written[ch][addr] = 1'b1;
            planned_items++;
            n_loads++;
        end else begin
            n_noise++;
        end
    endtask

    // fill any word the coming tick would fetch before it has ever been loaded
    task automatic queue_tick();
        stim_word_t w;
        int         p;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if ((plan_st.status[ch] & COUNT_MASK) == '0) begin
                p = plan_st.pos[ch];
                if (!plan_written[ch][p])
                    queue_load(ch, p, pick_word(p));
                if (plan_prog[ch][p] == loop_code_r && !plan_written[ch][0])
                    queue_load(ch, 0, pick_word(0));
            end
        end
        w = '0;
        w.mode = MODE_TICK;
        w.channel = 7'($urandom);
        w.value = 8'($urandom);
        push_word(w);
        plan_st = blink_step(plan_st, plan_prog);
        planned_items++;
        n_ticks++;
    endtask

    task automatic queue_restart();
        stim_word_t w;
        w = '0;
        w.mode = MODE_RESTART;
        w.addr = 6'($urandom);
        push_word(w);
        plan_st = '0;
        planned_items++;
        n_restarts++;
    endtask

    task automatic queue_noise();
        stim_word_t w;
        if ($urandom_range(0, 1) == 0) begin
            w.mode    = MODE_SPARE;
            w.channel = 7'($urandom);
            w.addr    = 6'($urandom);
            w.value   = 8'($urandom);
            push_word(w);
            n_noise++;
        end else begin
            queue_load($urandom_range(CHANNELS, 127), $urandom_range(0, 63), 8'($urandom));
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [WORD_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_LOOP_CODE: loop_code_r = v;
            CFG_HALT_CODE: halt_code_r = v;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_words.size() != 0 || accepted_total != queued_total ||
               exp_byte_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic queue_directed();
        queue_load(95, 63, 8'hFF);
        queue_load(127, 63, 8'hFF);
        queue_load(96, 5, 8'hAA);
        queue_noise();
        queue_restart();
        queue_load(0, 0, 8'h81);
        queue_load(0, 1, halt_code_r);
        queue_load(1, 0, loop_code_r);
        queue_load(2, 0, 8'h82);
        queue_load(2, 1, 8'h01);
        queue_load(2, 2, loop_code_r);
        queue_load(95, 0, 8'h7F);
        queue_load(94, 0, 8'hFF);
        queue_load(93, 0, 8'h00);
        queue_load(3, 0, 8'h80);
        queue_load(3, 1, 8'h00);
        queue_tick();
        queue_tick();
        queue_tick();
        queue_tick();
        queue_restart();
        queue_tick();
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_words.size() != 0 && !take_break()) begin
                drv_word = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_word.mode;
                s_tdata  <= {3'b000, drv_word.value, drv_word.addr, drv_word.channel};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !take_break();
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                bytes_checked++;
                if (exp_byte_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word %04h last %b", m_tdata, m_tlast));
                end else begin
                    want = exp_byte_q.pop_front();
                    if (m_tdata[7:0] !== want.led)
                        flag_mismatch($sformatf("led_byte at index %0d: got %02h, want %02h",
                                                want.index, m_tdata[7:0], want.led));
                    if (m_tdata[11:8] !== want.index)
                        flag_mismatch($sformatf("byte_index: got %0d, want %0d",
                                                m_tdata[11:8], want.index));
                    if (m_tlast !== want.last)
                        flag_mismatch($sformatf("last_byte at index %0d: got %b, want %b",
                                                want.index, m_tlast, want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                accepted_total++;
                case (s_tuser)
                    MODE_LOAD: begin
                        if (s_tdata[6:0] < CHANNELS)
                            live_prog[s_tdata[6:0]][s_tdata[12:7]] = s_tdata[20:13];
                    end
                    MODE_TICK: begin
                        live_st = blink_step(live_st, live_prog);
                        queue_led_frame(led_frame_of(live_st));
                    end
                    MODE_RESTART: begin
                        live_st = '0;
                        queue_led_frame('0);
                    end
                    default: ;
                endcase
            end
        end
    end

    initial begin
        logic [WORD_W-1:0] lc;
        logic [WORD_W-1:0] hc;
        int unsigned       phase_start;
        int unsigned       phase_ticks;
        int unsigned       r;
        int                ch;
        int                a;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin lc = 8'd128; hc = 8'd0;   end
                1: begin lc = 8'd0;   hc = 8'd255; end
                2: begin lc = 8'd255; hc = 8'd128; end
                3: begin lc = 8'($urandom); hc = 8'($urandom); end
                default: begin lc = 8'($urandom_range(1, 254)); hc = lc; end
            endcase
            wait_drain();
            write_reg(CFG_LOOP_CODE, lc);
            write_reg(CFG_HALT_CODE, hc);
            @(negedge aclk);
            phase_start = planned_items;
            phase_ticks = 0;
            if (ph == 0)
                queue_directed();
            while (planned_items - phase_start < PHASE_ITEMS || phase_ticks < 8) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    queue_tick();
                    phase_ticks++;
                end else if (r < 55) begin
                    queue_restart();
                end else if (r < 82) begin
                    ch = $urandom_range(0, CHANNELS - 1);
                    a  = $urandom_range(0, PROGRAM_DEPTH - 1);
                    queue_load(ch, a, ($urandom_range(0, 1) != 0) ? pick_word(a) : 8'($urandom));
                end else begin
                    queue_noise();
                end
            end
        end
        wait_drain();
        repeat (50) @(posedge aclk);
        $display("5 code settings; %0d loads, %0d ticks, %0d restarts, %0d ignored words",
                 n_loads, n_ticks, n_restarts, n_noise);
        $display("%0d output bytes checked, %0d mismatches", bytes_checked, err_count);
        if (err_count == 0 && exp_byte_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ multichannel_led_blink_sequencer_core.f @@
src/mlbs_pkg.sv
src/mlbs_frame_tx.sv
src/multichannel_led_blink_sequencer_core.sv
dv/tb_top.sv
